// File: rtl/cpo_pkg.sv
// cpo_pkg: shared constants of the capsule pair overlap block
// no dependencies
package cpo_pkg;

    localparam int Q_BITS = 16;
    localparam int DIGIT_W = 16;
    localparam int THR_W = 16;
    localparam int PARAM_W = 17;
    localparam int DIST_W = 50;
    localparam int OUT_FIELDS_W = 1 + DIST_W + 2 * PARAM_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [THR_W-1:0] THR_RESET = 16'd7;
    localparam logic [PARAM_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

// File: rtl/cpo_queue.sv
// cpo_queue: two-entry job queue between front and back
// uses no package items
module cpo_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         nonempty,
    output logic [W-1:0] dout
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign dout     = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/cpo_front.sv
// cpo_front: accepts capsule items, holds the first of a pair, forms jobs
// depends on cpo_pkg
module cpo_front #(
    parameter int CW = 24,
    parameter int JW = 12 * CW + 2 * (CW - 1) + cpo_pkg::THR_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cpo_pkg::THR_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7*CW-2:0]           s_tdata,
    input  logic                      s_tuser,
    input  logic                      q_full,
    output logic                      push,
    output logic [JW-1:0]             job
);

    logic [6*CW-1:0]           held_reg;
    logic [CW-2:0]             held_rad_reg;
    logic                      have_first_reg;
    logic [cpo_pkg::THR_W-1:0] thr_reg;
    logic                      accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept && s_tuser && have_first_reg;
    assign job       = {thr_reg, s_tdata[7*CW-2:6*CW], held_rad_reg,
                        s_tdata[6*CW-1:0], held_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            thr_reg        <= cpo_pkg::THR_RESET;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            if (accept) begin
                have_first_reg <= !s_tuser;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_tuser) begin
            held_reg     <= s_tdata[6*CW-1:0];
            held_rad_reg <= s_tdata[7*CW-2:6*CW];
        end
    end

endmodule

// File: rtl/cpo_mul.sv
// cpo_mul: signed multiplier, one 16-bit digit of b per cycle, msb first
// depends on cpo_pkg
module cpo_mul #(
    parameter int MW = 52
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [MW-1:0] a,
    input  logic signed [MW-1:0] b,
    output logic                 done,
    output logic signed [2*MW-1:0] p
);

    localparam int DG = cpo_pkg::DIGIT_W;
    localparam int NDIG = (MW + DG - 1) / DG;
    localparam int BPW = NDIG * DG;
    localparam int CNTW = $clog2(NDIG + 1);

    logic [MW-1:0]      mag_a_reg;
    logic [BPW-1:0]     mag_b_reg;
    logic [2*MW-1:0]    acc_reg;
    logic               neg_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [2*MW-1:0] p_reg;

    logic [MW-1:0]      a_abs;
    logic [MW-1:0]      b_abs;
    logic [MW+DG-1:0]   part;
    logic [2*MW-1:0]    acc_next;

    assign a_abs    = a[MW-1] ? (~a + 1'b1) : a;
    assign b_abs    = b[MW-1] ? (~b + 1'b1) : b;
    assign part     = mag_a_reg * mag_b_reg[BPW-1 -: DG];
    assign acc_next = (acc_reg << DG) + (2*MW)'(part);
    assign done     = done_reg;
    assign p        = p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NDIG);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= a_abs;
            mag_b_reg <= BPW'(b_abs);
            neg_reg   <= a[MW-1] ^ b[MW-1];
            acc_reg   <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                acc_reg   <= acc_next;
                mag_b_reg <= mag_b_reg << DG;
            end else begin
                p_reg <= neg_reg ? $signed(~acc_reg + 1'b1) : $signed(acc_reg);
            end
        end
    end

endmodule

// File: rtl/cpo_div.sv
// cpo_div: clamped Q1.16 quotient floor(num*65536/den), one bit per cycle
// depends on cpo_pkg
module cpo_div #(
    parameter int VW = 106
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [VW-1:0]        num,
    input  logic signed [VW-1:0]        den,
    output logic                        done,
    output logic [cpo_pkg::PARAM_W-1:0] q
);

    logic [VW-1:0]                rem_reg;
    logic [VW-1:0]                den_reg;
    logic [cpo_pkg::PARAM_W-1:0]  q_reg;
    logic [4:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [VW-1:0]                r2;
    logic                         fit;

    assign r2   = {rem_reg[VW-2:0], 1'b0};
    assign fit  = (r2 >= den_reg);
    assign done = done_reg;
    assign q    = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (num[VW-1] || num == '0 || num >= den) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'(cpo_pkg::Q_BITS);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            if (num[VW-1] || num == '0) begin
                q_reg <= '0;
            end else if (num >= den) begin
                q_reg <= cpo_pkg::ONE_Q16;
            end else begin
                q_reg <= '0;
            end
        end else if (busy_reg) begin
            rem_reg <= fit ? (r2 - den_reg) : r2;
            q_reg   <= {q_reg[cpo_pkg::PARAM_W-2:0], fit};
        end
    end

endmodule

// File: rtl/cpo_back.sv
// cpo_back: closest points of two segments, squared distance, radius test
// depends on cpo_pkg, cpo_mul, cpo_div
module cpo_back #(
    parameter int CW = 24,
    parameter int JW = 12 * CW + 2 * (CW - 1) + cpo_pkg::THR_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      job_valid,
    input  logic [JW-1:0]             job,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [cpo_pkg::OUT_W-1:0] m_tdata
);

    localparam int DW = CW + 1;
    localparam int XW = DW;
    localparam int YW = (DW > 18) ? DW : 18;
    localparam int PW = 2 * DW + 2;
    localparam int WVW = DW + 19;
    localparam int MW = (PW > WVW) ? PW : WVW;
    localparam int VW = 2 * MW + 2;
    localparam int HW = VW - 32;
    localparam int CMPW = HW + 64;
    localparam int PRW = cpo_pkg::PARAM_W;
    localparam int THW = cpo_pkg::THR_W;
    localparam int DIST_W_L = cpo_pkg::DIST_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DOT, ST_CLASS, ST_AE, ST_BB, ST_DEN, ST_BF, ST_CE, ST_DIVS,
        ST_NT, ST_NTW, ST_NTDEC, ST_DIVSF, ST_DIVT, ST_W1, ST_W2, ST_WSQ, ST_FIN
    } state_t;

    state_t               state_reg;
    logic [JW-1:0]        job_reg;
    logic [2:0]           dk_reg;
    logic [1:0]           comp_reg;
    logic signed [PW-1:0] a_reg, e_reg, f_reg, c_reg, b_reg;
    logic [2*CW-1:0]      rad2_reg;
    logic signed [VW-1:0] tmp_reg, denom_reg, num_t_reg, dist_reg;
    logic signed [WVW-1:0] wv_reg;
    logic [PRW-1:0]       s_reg, t_reg;
    logic                 mul_start_reg, div_start_reg;
    logic signed [MW-1:0] mul_a_reg, mul_b_reg;
    logic signed [VW-1:0] div_num_reg, div_den_reg;
    logic                 m_valid_reg;
    logic [cpo_pkg::OUT_W-1:0] m_data_reg;

    logic signed [DW-1:0] d1 [3];
    logic signed [DW-1:0] d2 [3];
    logic signed [DW-1:0] rv [3];
    logic [CW-1:0]        rsum;
    logic [THW-1:0]       thr;
    logic signed [XW-1:0] mx;
    logic signed [YW-1:0] my;
    logic signed [XW+YW-1:0] prod;
    logic                 mul_done, div_done;
    logic signed [2*MW-1:0] mul_p;
    logic [PRW-1:0]       div_q;
    logic signed [VW-1:0] mp, neg_c, b_minus_c, den_t, f_sh;
    logic signed [WVW-1:0] wv_next;
    logic                 a_pt, e_pt;
    logic [HW-1:0]        dist_hi;
    logic [CMPW-1:0]      dist_ext;
    logic [DIST_W_L-1:0]  dsq;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1[i] = DW'($signed(job_reg[(3+i)*CW +: CW]))
                  - DW'($signed(job_reg[i*CW +: CW]));
            d2[i] = DW'($signed(job_reg[(9+i)*CW +: CW]))
                  - DW'($signed(job_reg[(6+i)*CW +: CW]));
            rv[i] = DW'($signed(job_reg[i*CW +: CW]))
                  - DW'($signed(job_reg[(6+i)*CW +: CW]));
        end
    end

    assign rsum = {1'b0, job_reg[12*CW +: CW-1]} + {1'b0, job_reg[13*CW-1 +: CW-1]};
    assign thr  = job_reg[14*CW-2 +: THW];

    always_comb begin
        mx = '0;
        my = '0;
        case (state_reg)
            ST_DOT: begin
                case (dk_reg)
                    3'd0: begin
                        mx = d1[comp_reg];
                        my = YW'(d1[comp_reg]);
                    end
                    3'd1: begin
                        mx = d2[comp_reg];
                        my = YW'(d2[comp_reg]);
                    end
                    3'd2: begin
                        mx = d2[comp_reg];
                        my = YW'(rv[comp_reg]);
                    end
                    3'd3: begin
                        mx = d1[comp_reg];
                        my = YW'(rv[comp_reg]);
                    end
                    3'd4: begin
                        mx = d1[comp_reg];
                        my = YW'(d2[comp_reg]);
                    end
                    default: begin
                        mx = $signed({1'b0, rsum});
                        my = YW'($signed({1'b0, rsum}));
                    end
                endcase
            end
            ST_W1: begin
                mx = d1[comp_reg];
                my = YW'($signed({1'b0, s_reg}));
            end
            ST_W2: begin
                mx = d2[comp_reg];
                my = -(YW'($signed({1'b0, t_reg})));
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign prod      = mx * my;
    assign mp        = VW'(mul_p);
    assign neg_c     = -(VW'(c_reg));
    assign b_minus_c = VW'(b_reg) - VW'(c_reg);
    assign f_sh      = VW'(f_reg) <<< cpo_pkg::Q_BITS;
    assign den_t     = VW'(e_reg) <<< cpo_pkg::Q_BITS;
    assign wv_next   = wv_reg + WVW'(prod);
    assign a_pt      = (a_reg <= PW'($signed({1'b0, thr})));
    assign e_pt      = (e_reg <= PW'($signed({1'b0, thr})));
    assign dist_hi   = dist_reg[VW-1:32];
    assign dist_ext  = CMPW'(dist_hi);
    assign dsq       = (dist_ext >= CMPW'(cpo_pkg::DIST_MAX)) ? cpo_pkg::DIST_MAX
                                                            : dist_ext[DIST_W_L-1:0];

    assign pop      = (state_reg == ST_IDLE) && job_valid;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    cpo_mul #(.MW(MW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    cpo_div #(.VW(VW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg  <= job;
                        a_reg    <= '0;
                        e_reg    <= '0;
                        f_reg    <= '0;
                        c_reg    <= '0;
                        b_reg    <= '0;
                        dist_reg <= '0;
                        dk_reg   <= 3'd0;
                        comp_reg <= 2'd0;
                        state_reg <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    case (dk_reg)
                        3'd0: a_reg <= a_reg + PW'(prod);
                        3'd1: e_reg <= e_reg + PW'(prod);
                        3'd2: f_reg <= f_reg + PW'(prod);
                        3'd3: c_reg <= c_reg + PW'(prod);
                        3'd4: b_reg <= b_reg + PW'(prod);
                        default: rad2_reg <= prod[2*CW-1:0];
                    endcase
                    if (dk_reg == 3'd5) begin
                        state_reg <= ST_CLASS;
                    end else if (comp_reg == 2'd2) begin
                        comp_reg <= 2'd0;
                        dk_reg   <= dk_reg + 3'd1;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                ST_CLASS: begin
                    comp_reg <= 2'd0;
                    if (a_pt && e_pt) begin
                        s_reg     <= '0;
                        t_reg     <= '0;
                        state_reg <= ST_W1;
                    end else if (a_pt) begin
                        s_reg         <= '0;
                        div_num_reg   <= VW'(f_reg);
                        div_den_reg   <= VW'(e_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVT;
                    end else if (e_pt) begin
                        t_reg         <= '0;
                        div_num_reg   <= neg_c;
                        div_den_reg   <= VW'(a_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVSF;
                    end else begin
                        mul_a_reg     <= MW'(a_reg);
                        mul_b_reg     <= MW'(e_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_AE;
                    end
                end
                ST_AE: begin
                    if (mul_done) begin
                        tmp_reg       <= mp;
                        mul_a_reg     <= MW'(b_reg);
                        mul_b_reg     <= MW'(b_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_BB;
                    end
                end
                ST_BB: begin
                    if (mul_done) begin
                        denom_reg <= tmp_reg - mp;
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    if (!denom_reg[VW-1] && denom_reg != '0) begin
                        mul_a_reg     <= MW'(b_reg);
                        mul_b_reg     <= MW'(f_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_BF;
                    end else begin
                        s_reg     <= '0;
                        state_reg <= ST_NT;
                    end
                end
                ST_BF: begin
                    if (mul_done) begin
                        tmp_reg       <= mp;
                        mul_a_reg     <= MW'(c_reg);
                        mul_b_reg     <= MW'(e_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_CE;
                    end
                end
                ST_CE: begin
                    if (mul_done) begin
                        div_num_reg   <= tmp_reg - mp;
                        div_den_reg   <= denom_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVS;
                    end
                end
                ST_DIVS: begin
                    if (div_done) begin
                        s_reg     <= div_q;
                        state_reg <= ST_NT;
                    end
                end
                ST_NT: begin
                    mul_a_reg     <= MW'(b_reg);
                    mul_b_reg     <= MW'($signed({1'b0, s_reg}));
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_NTW;
                end
                ST_NTW: begin
                    if (mul_done) begin
                        num_t_reg <= mp + f_sh;
                        state_reg <= ST_NTDEC;
                    end
                end
                ST_NTDEC: begin
                    div_start_reg <= 1'b1;
                    if (num_t_reg[VW-1]) begin
                        t_reg       <= '0;
                        div_num_reg <= neg_c;
                        div_den_reg <= VW'(a_reg);
                        state_reg   <= ST_DIVSF;
                    end else if (num_t_reg > den_t) begin
                        t_reg       <= cpo_pkg::ONE_Q16;
                        div_num_reg <= b_minus_c;
                        div_den_reg <= VW'(a_reg);
                        state_reg   <= ST_DIVSF;
                    end else begin
                        div_num_reg <= num_t_reg;
                        div_den_reg <= den_t;
                        state_reg   <= ST_DIVT;
                    end
                end
                ST_DIVSF: begin
                    if (div_done) begin
                        s_reg     <= div_q;
                        comp_reg  <= 2'd0;
                        state_reg <= ST_W1;
                    end
                end
                ST_DIVT: begin
                    if (div_done) begin
                        t_reg     <= div_q;
                        comp_reg  <= 2'd0;
                        state_reg <= ST_W1;
                    end
                end
                ST_W1: begin
                    wv_reg    <= (WVW'(rv[comp_reg]) <<< cpo_pkg::Q_BITS) + WVW'(prod);
                    state_reg <= ST_W2;
                end
                ST_W2: begin
                    mul_a_reg     <= MW'(wv_next);
                    mul_b_reg     <= MW'(wv_next);
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_WSQ;
                end
                ST_WSQ: begin
                    if (mul_done) begin
                        dist_reg <= dist_reg + mp;
                        if (comp_reg == 2'd2) begin
                            state_reg <= ST_FIN;
                        end else begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_W1;
                        end
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= cpo_pkg::OUT_W'({t_reg, s_reg, dsq,
                                        dist_ext <= CMPW'(rad2_reg)});
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/capsule_pair_overlap.sv
// capsule_pair_overlap: top level, two capsules in a pair give one overlap result
// per pair: 16 dot steps, then up to five multiplies on the shared multiplier,
//   up to two 16-step divisions and three squares, all run by the back sequencer
// items enter at one a cycle while the two-entry job queue has room
// reset (aresetn, synchronous): no capsule held, queue and output empty, threshold 7
module capsule_pair_overlap #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cpo_pkg::THR_W-1:0] cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, radius, zero fill
    input  logic [((7*COORD_WIDTH+6)/8)*8-1:0] s_axis_tdata,
    // pair_position
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // overlap, dist_sq, param_s, param_t, zero fill
    output logic [cpo_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int JW = 12 * CW + 2 * (CW - 1) + cpo_pkg::THR_W;

    logic          q_full;
    logic          push;
    logic [JW-1:0] job_in;
    logic          job_valid;
    logic [JW-1:0] job_out;
    logic          pop;

    cpo_front #(.CW(CW), .JW(JW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata[7*CW-2:0]),
        .s_tuser   (s_axis_tuser),
        .q_full    (q_full),
        .push      (push),
        .job       (job_in)
    );

    cpo_queue #(.W(JW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .din      (job_in),
        .full     (q_full),
        .pop      (pop),
        .nonempty (job_valid),
        .dout     (job_out)
    );

    cpo_back #(.CW(CW), .JW(JW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job_out),
        .pop       (pop),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata)
    );

endmodule
